// ===== rtl/rpn_pkg.sv =====
// Shared constants, codes and types of the RPN stack calculator.
package rpn_pkg;

  localparam int STACK_DEPTH = 16;
  localparam int DATA_W      = 32;
  localparam int CMD_W       = 3;
  localparam int DEPTH_W     = 5;
  localparam int STATUS_W    = 2;
  localparam int PTR_W       = $clog2(STACK_DEPTH + 1);
  localparam int ADDR_W      = $clog2(STACK_DEPTH);
  localparam int DIV_STEPS   = DATA_W;
  localparam int STEP_W      = $clog2(DIV_STEPS + 1);
  localparam int IN_W        = ((CMD_W + DATA_W + 7) / 8) * 8;
  localparam int OUT_W       = ((DATA_W + DEPTH_W + STATUS_W + 7) / 8) * 8;

  typedef enum logic [CMD_W-1:0] {
    CMD_PUSH = 3'd0,
    CMD_ADD  = 3'd1,
    CMD_SUB  = 3'd2,
    CMD_MUL  = 3'd3,
    CMD_DIV  = 3'd4,
    CMD_DROP = 3'd5
  } cmd_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK      = 2'd0,
    ST_UNDER   = 2'd1,
    ST_OVER    = 2'd2,
    ST_DIVZERO = 2'd3
  } status_t;

  typedef struct packed {
    logic start;
    cmd_t op;
  } alu_req_t;

endpackage

// ===== rtl/rpn_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module rpn_ram #(
  parameter int WIDTH  = 32,
  parameter int DEPTH  = 16,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [WIDTH-1:0]  wr_data,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [WIDTH-1:0]  rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== rtl/rpn_alu.sv =====
// Shared arithmetic unit: registered add, subtract and multiply, radix-2 signed divide.
module rpn_alu (
  input  logic                     clk,
  input  logic                     rst,
  input  rpn_pkg::alu_req_t        req,
  input  logic [rpn_pkg::DATA_W-1:0] a,
  input  logic [rpn_pkg::DATA_W-1:0] b,
  output logic                     done,
  output logic [rpn_pkg::DATA_W-1:0] result
);

  logic                          busy;
  logic [rpn_pkg::STEP_W-1:0]    count;
  logic [rpn_pkg::DATA_W-1:0]    rem;
  logic [rpn_pkg::DATA_W-1:0]    quot;
  logic [rpn_pkg::DATA_W-1:0]    dvs;
  logic                          negq;
  logic [rpn_pkg::DATA_W:0]      shifted;
  logic [rpn_pkg::DATA_W:0]      diff;
  logic [rpn_pkg::DATA_W-1:0]    mag_a;
  logic [rpn_pkg::DATA_W-1:0]    mag_b;
  logic [2*rpn_pkg::DATA_W-1:0]  product;

  assign mag_a   = a[rpn_pkg::DATA_W-1] ? (~a + 1'b1) : a;
  assign mag_b   = b[rpn_pkg::DATA_W-1] ? (~b + 1'b1) : b;
  assign product = a * b;
  assign shifted = {rem, quot[rpn_pkg::DATA_W-1]};
  assign diff    = shifted - {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (busy) begin
        if (count == rpn_pkg::STEP_W'(rpn_pkg::DIV_STEPS)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end else if (req.start) begin
        if (req.op == rpn_pkg::CMD_DIV) begin
          busy <= 1'b1;
        end else begin
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (busy) begin
      if (count == rpn_pkg::STEP_W'(rpn_pkg::DIV_STEPS)) begin
        result <= negq ? (~quot + 1'b1) : quot;
      end else begin
        quot  <= {quot[rpn_pkg::DATA_W-2:0], ~diff[rpn_pkg::DATA_W]};
        rem   <= diff[rpn_pkg::DATA_W] ? shifted[rpn_pkg::DATA_W-1:0]
                                       : diff[rpn_pkg::DATA_W-1:0];
        count <= count + 1'b1;
      end
    end else if (req.start) begin
      case (req.op)
        rpn_pkg::CMD_ADD: result <= a + b;
        rpn_pkg::CMD_SUB: result <= a - b;
        rpn_pkg::CMD_MUL: result <= product[rpn_pkg::DATA_W-1:0];
        default: begin
          rem   <= '0;
          quot  <= mag_a;
          dvs   <= mag_b;
          negq  <= a[rpn_pkg::DATA_W-1] ^ b[rpn_pkg::DATA_W-1];
          count <= '0;
        end
      endcase
    end
  end

endmodule

// ===== rtl/rpn_stack_calculator_top.sv =====
// Top level of the RPN stack calculator: sequencer, top-of-stack register and stack RAM.
//
// Each input item pushes a value, applies add, subtract, multiply or divide to the two
// top entries, or discards the top entry, and yields exactly one result item with the
// new top, the depth and a status; an unused command code leaves the stack unchanged.
// The block handles one item at a time. Divide uses the 32-step radix-2 divider in the
// shared arithmetic unit. The top entry is held in a register and the entries below it
// in a RAM with one read and one write port. A finished result waits in the output
// register while the next item is taken in.
module rpn_stack_calculator_top (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      s_axis_tvalid,
  output logic                      s_axis_tready,
  // command [2:0], operand [34:3], zero fill above.
  input  logic [rpn_pkg::IN_W-1:0]  s_axis_tdata,
  output logic                      m_axis_tvalid,
  input  logic                      m_axis_tready,
  // top_value [31:0], stack_depth [36:32], status [38:37], zero fill above.
  output logic [rpn_pkg::OUT_W-1:0] m_axis_tdata
);

  typedef enum logic [5:0] {
    S_IDLE   = 6'b000001,
    S_DECODE = 6'b000010,
    S_EXEC   = 6'b000100,
    S_WAIT   = 6'b001000,
    S_LOAD   = 6'b010000,
    S_DONE   = 6'b100000
  } state_t;

  localparam int PAD_W = rpn_pkg::OUT_W - rpn_pkg::DATA_W - rpn_pkg::DEPTH_W
                         - rpn_pkg::STATUS_W;

  state_t                          state;
  state_t                          state_next;
  logic [rpn_pkg::CMD_W-1:0]       cmd;
  logic [rpn_pkg::DATA_W-1:0]      opnd;
  logic [rpn_pkg::DATA_W-1:0]      top;
  logic [rpn_pkg::PTR_W-1:0]       sp;
  rpn_pkg::status_t                status;
  rpn_pkg::alu_req_t               alu_req;
  logic                            alu_done;
  logic [rpn_pkg::DATA_W-1:0]      alu_result;
  logic                            wr_en;
  logic                            rd_en;
  logic [rpn_pkg::PTR_W-1:0]       sp_minus1;
  logic [rpn_pkg::PTR_W-1:0]       sp_minus2;
  logic [rpn_pkg::DATA_W-1:0]      rd_data;
  logic                            full;
  logic                            one_or_less;
  logic                            empty;
  logic [rpn_pkg::DATA_W-1:0]      top_out;

  assign sp_minus1   = sp - rpn_pkg::PTR_W'(1);
  assign sp_minus2   = sp - rpn_pkg::PTR_W'(2);
  assign full        = (sp == rpn_pkg::PTR_W'(rpn_pkg::STACK_DEPTH));
  assign empty       = (sp == '0);
  assign one_or_less = (sp < rpn_pkg::PTR_W'(2));
  assign top_out     = empty ? '0 : top;

  assign s_axis_tready = (state == S_IDLE);

  always_comb begin
    state_next  = state;
    wr_en       = 1'b0;
    rd_en       = 1'b0;
    alu_req     = '{start: 1'b0, op: rpn_pkg::cmd_t'(cmd)};
    unique case (state)
      S_IDLE: begin
        if (s_axis_tvalid) begin
          state_next = S_DECODE;
        end
      end
      S_DECODE: begin
        state_next = S_DONE;
        unique case (cmd) inside
          rpn_pkg::CMD_PUSH: begin
            wr_en = !full && !empty;
          end
          rpn_pkg::CMD_ADD, rpn_pkg::CMD_SUB, rpn_pkg::CMD_MUL, rpn_pkg::CMD_DIV: begin
            if (!one_or_less && !(cmd == rpn_pkg::CMD_DIV && top == '0)) begin
              rd_en      = 1'b1;
              state_next = S_EXEC;
            end
          end
          rpn_pkg::CMD_DROP: begin
            if (!one_or_less) begin
              rd_en      = 1'b1;
              state_next = S_LOAD;
            end
          end
          default: begin
            state_next = S_DONE;
          end
        endcase
      end
      S_EXEC: begin
        alu_req.start = 1'b1;
        state_next    = S_WAIT;
      end
      S_WAIT: begin
        if (alu_done) begin
          state_next = S_DONE;
        end
      end
      S_LOAD: begin
        state_next = S_DONE;
      end
      S_DONE: begin
        if (!m_axis_tvalid || m_axis_tready) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      sp            <= '0;
      m_axis_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == S_DONE && (!m_axis_tvalid || m_axis_tready)) begin
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
      if (state == S_DECODE) begin
        if (cmd == rpn_pkg::CMD_PUSH && !full) begin
          sp <= sp + rpn_pkg::PTR_W'(1);
        end else if (cmd == rpn_pkg::CMD_DROP && !empty) begin
          sp <= sp_minus1;
        end
      end
      if (state == S_WAIT && alu_done) begin
        sp <= sp_minus1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_IDLE && s_axis_tvalid) begin
      cmd  <= s_axis_tdata[rpn_pkg::CMD_W-1:0];
      opnd <= s_axis_tdata[rpn_pkg::CMD_W +: rpn_pkg::DATA_W];
    end
    if (state == S_DECODE) begin
      unique case (cmd) inside
        rpn_pkg::CMD_PUSH: begin
          if (full) begin
            status <= rpn_pkg::ST_OVER;
          end else begin
            status <= rpn_pkg::ST_OK;
            top    <= opnd;
          end
        end
        rpn_pkg::CMD_ADD, rpn_pkg::CMD_SUB, rpn_pkg::CMD_MUL, rpn_pkg::CMD_DIV: begin
          if (one_or_less) begin
            status <= rpn_pkg::ST_UNDER;
          end else if (cmd == rpn_pkg::CMD_DIV && top == '0) begin
            status <= rpn_pkg::ST_DIVZERO;
          end else begin
            status <= rpn_pkg::ST_OK;
          end
        end
        rpn_pkg::CMD_DROP: begin
          if (empty) begin
            status <= rpn_pkg::ST_UNDER;
          end else begin
            status <= rpn_pkg::ST_OK;
          end
        end
        default: begin
          status <= rpn_pkg::ST_OK;
        end
      endcase
    end
    if (state == S_WAIT && alu_done) begin
      top <= alu_result;
    end
    if (state == S_LOAD) begin
      top <= rd_data;
    end
    if (state == S_DONE && (!m_axis_tvalid || m_axis_tready)) begin
      m_axis_tdata <= {{PAD_W{1'b0}}, status, rpn_pkg::DEPTH_W'(sp), top_out};
    end
  end

  rpn_ram #(
    .WIDTH (rpn_pkg::DATA_W),
    .DEPTH (rpn_pkg::STACK_DEPTH),
    .ADDR_W(rpn_pkg::ADDR_W)
  ) u_stack (
    .clk    (clk),
    .wr_en  (wr_en),
    .wr_addr(sp_minus1[rpn_pkg::ADDR_W-1:0]),
    .wr_data(top),
    .rd_en  (rd_en),
    .rd_addr(sp_minus2[rpn_pkg::ADDR_W-1:0]),
    .rd_data(rd_data)
  );

  rpn_alu u_alu (
    .clk   (clk),
    .rst   (rst),
    .req   (alu_req),
    .a     (rd_data),
    .b     (top),
    .done  (alu_done),
    .result(alu_result)
  );

endmodule

// ===== bench/tb_rpn_stack_calculator_top.sv =====
// Self-checking testbench for the RPN stack calculator: shadow stack, random stream traffic.
`timescale 1ns / 1ps

module tb_rpn_stack_calculator_top;
  import rpn_pkg::*;

  localparam logic [CMD_W-1:0] CMD_SPARE_A = 3'd6;
  localparam logic [CMD_W-1:0] CMD_SPARE_B = 3'd7;
  localparam int HOLD_CYCLES    = 400;
  localparam int WATCHDOG_LIMIT = 3000;
  localparam int TAIL_CYCLES    = 60;
  localparam int RANDOM_ITEMS   = 330;

  typedef struct packed {
    logic [DATA_W-1:0]  top;
    logic [DEPTH_W-1:0] depth;
    status_t            status;
  } calc_result_t;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             s_axis_tvalid = 1'b0;
  logic             s_axis_tready;
  logic [IN_W-1:0]  s_axis_tdata = '0;
  logic             m_axis_tvalid;
  logic             m_axis_tready = 1'b0;
  logic [OUT_W-1:0] m_axis_tdata;

  logic [DATA_W-1:0] shadow_stack [STACK_DEPTH];
  int                shadow_depth = 0;
  calc_result_t      pending_results [$];
  int                error_count = 0;
  int                burst_left = 0;
  bit                steady_send = 1'b0;
  int                hold_asks = 0;
  int                hold_grants = 0;
  int                hold_left = 0;
  int                rx_cycle = 0;
  int                rx_mode = 0;
  int                idle_cycles = 0;

  rpn_stack_calculator_top uut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic calc_result_t evaluate_command(logic [CMD_W-1:0] cmd,
                                                    logic [DATA_W-1:0] val);
    calc_result_t res;
    logic [DATA_W-1:0] a, b, r, ma, mb, q;
    logic ok;
    res = '0;
    res.status = ST_OK;
    ok = 1'b1;
    r = '0;
    if (cmd == CMD_PUSH) begin
      if (shadow_depth >= STACK_DEPTH) begin
        res.status = ST_OVER;
      end else begin
        shadow_stack[shadow_depth] = val;
        shadow_depth++;
      end
    end else if (cmd == CMD_ADD || cmd == CMD_SUB || cmd == CMD_MUL || cmd == CMD_DIV) begin
      if (shadow_depth < 2) begin
        res.status = ST_UNDER;
      end else begin
        a = shadow_stack[shadow_depth-2];
        b = shadow_stack[shadow_depth-1];
        if (cmd == CMD_ADD) begin
          r = a + b;
        end else if (cmd == CMD_SUB) begin
          r = a - b;
        end else if (cmd == CMD_MUL) begin
          r = a * b;
        end else if (b == '0) begin
          ok = 1'b0;
          res.status = ST_DIVZERO;
        end else begin
          ma = a[DATA_W-1] ? -a : a;
          mb = b[DATA_W-1] ? -b : b;
          q = ma / mb;
          r = (a[DATA_W-1] ^ b[DATA_W-1]) ? -q : q;
        end
        if (ok) begin
          shadow_stack[shadow_depth-2] = r;
          shadow_depth--;
        end
      end
    end else if (cmd == CMD_DROP) begin
      if (shadow_depth == 0) begin
        res.status = ST_UNDER;
      end else begin
        shadow_depth--;
      end
    end
    res.top = (shadow_depth == 0) ? '0 : shadow_stack[shadow_depth-1];
    res.depth = DEPTH_W'(shadow_depth);
    return res;
  endfunction

  function automatic logic [DATA_W-1:0] random_operand();
    int pick;
    pick = $urandom_range(0, 9);
    case (pick)
      0: return 32'h0000_0000;
      1: return 32'h0000_0001;
      2: return 32'hFFFF_FFFF;
      3: return 32'h8000_0000;
      4: return 32'h7FFF_FFFF;
      5: return DATA_W'($urandom_range(0, 20)) - 32'd10;
      6: return DATA_W'($urandom_range(0, 65535));
      default: return $urandom;
    endcase
  endfunction

  task automatic report_mismatch(string what, logic [DATA_W-1:0] got, logic [DATA_W-1:0] want);
    $display("%0t ns: mismatch in %s: got 0x%08h, expected 0x%08h", $time, what, got, want);
    error_count++;
  endtask

  task automatic send_item(logic [CMD_W-1:0] cmd, logic [DATA_W-1:0] val);
    int gap;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {{(IN_W-CMD_W-DATA_W){1'b0}}, val, cmd};
    do @(posedge clk); while (!s_axis_tready);
    pending_results.push_back(evaluate_command(cmd, val));
    if (!steady_send) begin
      if (burst_left > 0) begin
        burst_left--;
      end else begin
        s_axis_tvalid <= 1'b0;
        gap = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 6);
        repeat (gap) @(posedge clk);
        burst_left = $urandom_range(0, 12);
      end
    end
  endtask

  task automatic test_basic_ops();
    send_item(CMD_DROP, 32'h1234_5678);
    send_item(CMD_ADD,  32'hFFFF_FFFF);
    send_item(CMD_PUSH, 32'h7FFF_FFFF);
    send_item(CMD_SUB,  32'h0);
    send_item(CMD_MUL,  32'h0);
    send_item(CMD_DIV,  32'h0);
    send_item(CMD_PUSH, 32'h0000_0001);
    send_item(CMD_ADD,  32'h0);
    send_item(CMD_PUSH, 32'hFFFF_FFFF);
    send_item(CMD_DIV,  32'h0);
    send_item(CMD_PUSH, 32'h0000_0000);
    send_item(CMD_DIV,  32'h0);
    send_item(CMD_DROP, 32'h0);
    send_item(CMD_PUSH, 32'hFFFF_FFFF);
    send_item(CMD_MUL,  32'h0);
    send_item(CMD_PUSH, 32'd7);
    send_item(CMD_PUSH, -32'sd2);
    send_item(CMD_DIV,  32'h0);
    send_item(CMD_SUB,  32'h0);
    send_item(CMD_PUSH, 32'h8000_0000);
    send_item(CMD_SPARE_A, 32'hFFFF_FFFF);
    send_item(CMD_SPARE_B, 32'h5555_AAAA);
    send_item(CMD_DROP, 32'h0);
    send_item(CMD_DROP, 32'h0);
  endtask

  task automatic test_stack_limits();
    while (shadow_depth < STACK_DEPTH) send_item(CMD_PUSH, random_operand());
    send_item(CMD_PUSH, 32'h7FFF_FFFF);
    send_item(CMD_PUSH, 32'h8000_0000);
    send_item(CMD_ADD, 32'h0);
    while (shadow_depth > 0) send_item(CMD_DROP, $urandom);
    send_item(CMD_DROP, 32'h0);
  endtask

  task automatic test_output_backpressure();
    int i;
    steady_send = 1'b1;
    hold_asks <= hold_asks + 1;
    for (i = 0; i < 12; i++) begin
      send_item((i % 3 == 2) ? CMD_ADD : CMD_PUSH, random_operand());
    end
    steady_send = 1'b0;
  endtask

  task automatic test_random_programs(int count);
    int i, roll, target;
    logic [CMD_W-1:0] cmd;
    target = 0;
    for (i = 0; i < count; i++) begin
      if (i % 40 == 0) target = $urandom_range(0, STACK_DEPTH + 1);
      roll = $urandom_range(0, 99);
      if (roll < 4) begin
        cmd = $urandom_range(0, 1) ? CMD_SPARE_B : CMD_SPARE_A;
      end else if (roll < 9) begin
        cmd = CMD_W'($urandom_range(0, 7));
      end else if (shadow_depth < target) begin
        cmd = (roll < 75) ? CMD_PUSH : CMD_W'($urandom_range(1, 5));
      end else begin
        cmd = (roll < 30) ? CMD_PUSH : CMD_W'($urandom_range(1, 5));
      end
      send_item(cmd, random_operand());
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else if (hold_left > 0) begin
      m_axis_tready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (hold_grants != hold_asks) begin
      hold_grants <= hold_grants + 1;
      hold_left <= HOLD_CYCLES;
      m_axis_tready <= 1'b0;
    end else begin
      rx_cycle <= rx_cycle + 1;
      if (rx_cycle % 64 == 0) rx_mode <= $urandom_range(0, 3);
      case (rx_mode)
        0: m_axis_tready <= 1'b1;
        1: m_axis_tready <= ($urandom_range(0, 9) < 7);
        2: m_axis_tready <= (rx_cycle % 5 != 0);
        default: m_axis_tready <= ($urandom_range(0, 9) < 3);
      endcase
    end
  end

  always @(posedge clk) begin
    calc_result_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected item", m_axis_tdata[DATA_W-1:0], '0);
      end else begin
        want = pending_results.pop_front();
        if (m_axis_tdata[DATA_W-1:0] !== want.top)
          report_mismatch("top_value", m_axis_tdata[DATA_W-1:0], want.top);
        if (m_axis_tdata[DATA_W +: DEPTH_W] !== want.depth)
          report_mismatch("stack_depth", DATA_W'(m_axis_tdata[DATA_W +: DEPTH_W]),
                          DATA_W'(want.depth));
        if (m_axis_tdata[DATA_W+DEPTH_W +: STATUS_W] !== want.status)
          report_mismatch("status", DATA_W'(m_axis_tdata[DATA_W+DEPTH_W +: STATUS_W]),
                          DATA_W'(want.status));
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("tb_rpn_stack_calculator_top: FAIL");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    test_basic_ops();
    test_stack_limits();
    test_output_backpressure();
    test_random_programs(RANDOM_ITEMS);
    s_axis_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("tb_rpn_stack_calculator_top: PASS");
    end else begin
      $display("tb_rpn_stack_calculator_top: FAIL");
    end
    $finish;
  end

endmodule

// ===== rpn_stack_calculator_top.f =====
rtl/rpn_pkg.sv
rtl/rpn_ram.sv
rtl/rpn_alu.sv
rtl/rpn_stack_calculator_top.sv
bench/tb_rpn_stack_calculator_top.sv
